// ----- design/bmpp_pkg.sv -----
package bmpp_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned PackW   = 12;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned MaxBytes = 3;
  localparam int unsigned CntW    = 2;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_PACKED_TWELVE_BIT = 1'b0,
    CFG_SOURCE_IS_RGB     = 1'b1
  } cfg_idx_t;

  // One input pixel word
  typedef struct packed {
    logic [SampleW-1:0] raw_sample;
    logic [ChanW-1:0]   red;
    logic [ChanW-1:0]   green;
    logic [ChanW-1:0]   blue;
    logic               line_end;
    logic               frame_end;
  } pixel_t;

  // Output mode registers
  typedef struct packed {
    logic packed_twelve_bit;
    logic source_is_rgb;
  } mode_t;

  // Mosaic position and the held first pixel of a 12-bit pair
  typedef struct packed {
    logic             row_odd;
    logic             column_odd;
    logic [PackW-1:0] held_first_value;
  } mosaic_state_t;

  // Bytes produced by one pixel, plus the hold request for a pair start
  typedef struct packed {
    logic [CntW-1:0]                count;
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic                           hold;
    logic [PackW-1:0]               hold_value;
  } format_t;

endpackage

// ----- design/bmpp_format.sv -----
module bmpp_format (
  input  bmpp_pkg::pixel_t        pixel,
  input  bmpp_pkg::mode_t         mode,
  input  bmpp_pkg::mosaic_state_t mosaic,
  output bmpp_pkg::format_t       result
);

  logic [bmpp_pkg::ChanW-1:0] chan;
  logic [bmpp_pkg::PackW-1:0] value;
  logic [bmpp_pkg::PackW-1:0] first;
  logic [bmpp_pkg::PackW-1:0] second;

  // Pick the RGGB channel from row and column parity
  always_comb begin
    if (mosaic.row_odd) begin
      chan = mosaic.column_odd ? pixel.blue : pixel.green;
    end else begin
      chan = mosaic.column_odd ? pixel.green : pixel.red;
    end
  end

  // Reduce the pixel to its 12-bit value
  assign value = mode.source_is_rgb ? {chan, 4'h0} : pixel.raw_sample[15:4];

  // Choose the pair halves: held plus current, or current with a zero partner
  assign first  = mosaic.column_odd ? mosaic.held_first_value : value;
  assign second = mosaic.column_odd ? value : '0;

  // Build the byte group for this pixel
  always_comb begin
    result = '0;
    if (!mode.packed_twelve_bit) begin
      result.count = bmpp_pkg::CntW'(2);
      if (mode.source_is_rgb) begin
        result.bytes[0] = 8'h00;
        result.bytes[1] = chan;
      end else begin
        result.bytes[0] = pixel.raw_sample[7:0];
        result.bytes[1] = pixel.raw_sample[15:8];
      end
    end else if (mosaic.column_odd || pixel.line_end || pixel.frame_end) begin
      result.count    = bmpp_pkg::CntW'(3);
      result.bytes[0] = first[7:0];
      result.bytes[1] = {second[3:0], first[11:8]};
      result.bytes[2] = second[11:4];
    end else begin
      result.hold       = 1'b1;
      result.hold_value = value;
    end
  end

endmodule

// ----- design/bayer_mosaic_pixel_packer.sv -----
// Bayer mosaic pixel packer: takes one pixel word (raw 16-bit sample or 8-bit
// RGB reduced to its RGGB channel) and streams destination bytes in memory
// order, one byte per cycle on the master side while m_tready is high. In
// 16-bit mode each pixel gives two bytes, and the next pixel moves into the
// result register as the last byte of the one before leaves. In 12-bit mode a
// pixel pair gives three bytes: the pixel on the even column gives no bytes,
// yet it still waits for the result register to free up and then passes on its
// own, leaving an idle gap on the byte port per pair. A lone pixel that ends a
// line or frame gives three bytes. The rate is set by the single byte-wide
// output port and that idle gap for the held pixel. A pixel passes an input
// register and then a three-byte result register, from which its bytes are
// driven. Configuration writes are taken at any time and must only be made
// while the block is idle; they never touch the row, column or held state.
module bayer_mosaic_pixel_packer (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [0:0]  cfg_data,
  // pixel input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // raw_sample[15:0], red[23:16], green[31:24], blue[39:32]
  input  logic        s_tlast,   // line_end
  input  logic [0:0]  s_tuser,   // frame_end
  // byte output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte[7:0]
  output logic        m_tlast    // last_of_run
);

  bmpp_pkg::mode_t         mode;
  bmpp_pkg::mosaic_state_t mosaic;
  bmpp_pkg::pixel_t        in_pix;
  bmpp_pkg::format_t       fmt;
  logic                    in_valid;
  logic                    res_free;
  logic                    advance;
  logic [bmpp_pkg::CntW-1:0]                               cnt;
  logic [bmpp_pkg::MaxBytes-1:0][bmpp_pkg::ByteW-1:0]      bytes;

  assign cfg_ready = 1'b1;

  // Result register frees up when empty or its last byte leaves now
  assign res_free = (cnt == '0) || ((cnt == bmpp_pkg::CntW'(1)) && m_tready);
  assign advance  = in_valid && res_free;
  assign s_tready = !in_valid || res_free;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bmpp_pkg::cfg_idx_t'(cfg_index))
        bmpp_pkg::CFG_PACKED_TWELVE_BIT: mode.packed_twelve_bit <= cfg_data[0];
        bmpp_pkg::CFG_SOURCE_IS_RGB:     mode.source_is_rgb     <= cfg_data[0];
      endcase
    end
  end

  // Input register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // Capture the pixel word
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_pix.raw_sample <= s_tdata[15:0];
      in_pix.red        <= s_tdata[23:16];
      in_pix.green      <= s_tdata[31:24];
      in_pix.blue       <= s_tdata[39:32];
      in_pix.line_end   <= s_tlast;
      in_pix.frame_end  <= s_tuser[0];
    end
  end

  bmpp_format u_format (
    .pixel  (in_pix),
    .mode   (mode),
    .mosaic (mosaic),
    .result (fmt)
  );

  // Advance mosaic position and the held pair value
  always_ff @(posedge clk) begin
    if (rst) begin
      mosaic <= '0;
    end else if (advance) begin
      if (fmt.hold) begin
        mosaic.held_first_value <= fmt.hold_value;
      end
      if (in_pix.frame_end) begin
        mosaic.row_odd    <= 1'b0;
        mosaic.column_odd <= 1'b0;
      end else if (in_pix.line_end) begin
        mosaic.row_odd    <= !mosaic.row_odd;
        mosaic.column_odd <= 1'b0;
      end else begin
        mosaic.column_odd <= !mosaic.column_odd;
      end
    end
  end

  // Load or drain the byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (advance) begin
      cnt <= fmt.count;
    end else if (m_tvalid && m_tready) begin
      cnt <= cnt - bmpp_pkg::CntW'(1);
    end
  end

  // Load or shift the result bytes
  always_ff @(posedge clk) begin
    if (advance) begin
      bytes <= fmt.bytes;
    end else if (m_tvalid && m_tready) begin
      bytes <= {8'h00, bytes[bmpp_pkg::MaxBytes-1:1]};
    end
  end

  assign m_tvalid = (cnt != '0);
  assign m_tdata  = bytes[0];
  assign m_tlast  = (cnt == bmpp_pkg::CntW'(1));

endmodule
